FILE: hw/rtl/u8d_pkg.sv
// Shared types and constants for the UTF-8 stream decoder.
`default_nettype none
package u8d_pkg;

  localparam int CP_W      = 21;
  localparam int BYTE_W    = 8;
  localparam int REM_W     = 2;
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W     = $clog2(FIFO_DEPTH);
  localparam int CNT_W     = $clog2(FIFO_DEPTH + 1);
  localparam int OUT_DATA_W = ((CP_W + 7) / 8) * 8;

  localparam logic [CP_W-1:0] REPLACEMENT_CP = CP_W'(24'h00FFFD);

  typedef struct packed {
    logic [CP_W-1:0] code_point;
    logic            was_replaced;
    logic            last_of_run;
  } res_t;

  // Results produced by one accepted byte, in order: r0 first.
  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } push_t;

endpackage
`default_nettype wire

FILE: hw/rtl/u8d_decode.sv
// Per-byte decode: sequence state and the results each byte causes.
`default_nettype none
module u8d_decode (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       fire,
  input  wire logic [u8d_pkg::BYTE_W-1:0] data_byte,
  input  wire logic                       end_of_text,
  output u8d_pkg::push_t                  push
);
  import u8d_pkg::*;

  logic [REM_W-1:0] rem_r, rem_nxt;
  logic [CP_W-1:0]  part_r, part_nxt;

  logic             fr_emit, fr_rep;
  logic [CP_W-1:0]  fr_cp;
  logic [REM_W-1:0] fr_rem;
  logic [CP_W-1:0]  fr_part;

  always_comb begin
    fr_emit = 1'b0;
    fr_rep  = 1'b0;
    fr_cp   = '0;
    fr_rem  = '0;
    fr_part = '0;
    if (data_byte[7] == 1'b0) begin
      fr_emit = 1'b1;
      fr_cp   = CP_W'(data_byte);
    end else if (data_byte[7:5] == 3'b110) begin
      fr_rem  = REM_W'(1);
      fr_part = CP_W'(data_byte[4:0]);
    end else if (data_byte[7:4] == 4'b1110) begin
      fr_rem  = REM_W'(2);
      fr_part = CP_W'(data_byte[3:0]);
    end else if (data_byte[7:3] == 5'b11110) begin
      fr_rem  = REM_W'(3);
      fr_part = CP_W'(data_byte[2:0]);
    end else begin
      fr_emit = 1'b1;
      fr_rep  = 1'b1;
      fr_cp   = REPLACEMENT_CP;
    end
  end

  logic            is_cont;
  logic            intr;
  logic            main_emit, main_rep;
  logic [CP_W-1:0] main_cp;
  logic [CP_W-1:0] acc;
  logic            trunc;
  res_t            slot [2];
  logic [1:0]      cnt;

  always_comb begin
    is_cont   = (data_byte[7:6] == 2'b10);
    intr      = 1'b0;
    acc       = {part_r[CP_W-7:0], data_byte[5:0]};
    main_emit = fr_emit;
    main_rep  = fr_rep;
    main_cp   = fr_cp;
    rem_nxt   = fr_rem;
    part_nxt  = fr_part;
    if (rem_r != '0) begin
      if (is_cont) begin
        rem_nxt   = rem_r - REM_W'(1);
        main_rep  = 1'b0;
        main_cp   = acc;
        main_emit = (rem_nxt == '0);
        part_nxt  = (rem_nxt == '0) ? '0 : acc;
      end else begin
        intr = 1'b1;
      end
    end
    trunc = end_of_text && (rem_nxt != '0);
    if (end_of_text) begin
      rem_nxt  = '0;
      part_nxt = '0;
    end

    slot[0] = '0;
    slot[1] = '0;
    cnt     = 2'd0;
    if (intr) begin
      slot[cnt[0]] = '{code_point: REPLACEMENT_CP, was_replaced: 1'b1, last_of_run: 1'b0};
      cnt = cnt + 2'd1;
    end
    if (main_emit) begin
      slot[cnt[0]] = '{code_point: main_cp, was_replaced: main_rep, last_of_run: 1'b0};
      cnt = cnt + 2'd1;
    end
    if (trunc) begin
      slot[cnt[0]] = '{code_point: REPLACEMENT_CP, was_replaced: 1'b1, last_of_run: 1'b0};
      cnt = cnt + 2'd1;
    end
    slot[0].last_of_run = (cnt == 2'd1);
    slot[1].last_of_run = 1'b1;

    push.n  = fire ? cnt : 2'd0;
    push.r0 = slot[0];
    push.r1 = slot[1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r  <= '0;
      part_r <= '0;
    end else if (fire) begin
      rem_r  <= rem_nxt;
      part_r <= part_nxt;
    end
  end

  a_eot_clears: assert property (@(posedge clk) disable iff (!rst_n)
    fire && end_of_text |=> rem_r == '0 && part_r == '0)
    else $error("sequence state not cleared after end of text");
  a_max_two: assert property (@(posedge clk) disable iff (!rst_n)
    push.n != 2'd3)
    else $error("more than two results for one byte");
  a_idle_part: assert property (@(posedge clk) disable iff (!rst_n)
    rem_r == '0 |-> part_r == '0)
    else $error("partial value held with no sequence open");

endmodule
`default_nettype wire

FILE: hw/rtl/u8d_outq.sv
// Result queue: takes up to two results per cycle, gives one per cycle while the reader is ready.
`default_nettype none
module u8d_outq (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire u8d_pkg::push_t push,
  output logic                room2,
  output logic                rd_valid,
  input  wire logic           rd_ready,
  output u8d_pkg::res_t       rd_data
);
  import u8d_pkg::*;

  res_t             mem [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             pop;

  assign rd_valid = (count_r != '0);
  assign rd_data  = mem[rd_ptr_r];
  assign room2    = (count_r <= CNT_W'(FIFO_DEPTH - 2));
  assign pop      = rd_valid && rd_ready;
  assign count_nxt = count_r + CNT_W'(push.n) - CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      mem[wr_ptr_r] <= push.r0;
    end
    if (push.n == 2'd2) begin
      mem[wr_ptr_r + PTR_W'(1)] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + PTR_W'(push.n);
      rd_ptr_r <= rd_ptr_r + PTR_W'(pop);
      count_r  <= count_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(FIFO_DEPTH))
    else $error("result queue overflow");
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push.n != 2'd0 |-> room2)
    else $error("results pushed without room");
  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != CNT_W'(FIFO_DEPTH) |-> PTR_W'(count_r) == PTR_W'(wr_ptr_r - rd_ptr_r))
    else $error("queue pointers disagree with count");

endmodule
`default_nettype wire

FILE: hw/rtl/utf8_stream_decoder.sv
// Top level of the UTF-8 stream decoder.
//
// Usage:
//   Input channel (in_*): one UTF-8 byte per request in in_tdata[7:0];
//   in_tlast marks the last byte of a text. Output channel (out_*): one
//   code point per request in out_tdata[20:0]; out_tuser is high when the
//   code point is a substituted U+FFFD; out_tlast marks the final result
//   caused by one input byte. A byte causes zero, one or two results.
//   Results enter the result queue in order as their byte is accepted.
//   Throughput: one byte per cycle while the results drain at one per cycle;
//   a byte that causes two results has them read out one at a time from
//   the single-read result queue (four entries).
//   in_tready is high while the queue has room for two results, so the
//   input keeps moving while a result waits on a stalled receiver; a long
//   stall fills the queue and then holds in_tready low.
//   Reset (rst_n low, synchronous) empties the queue and closes any open
//   multi-byte sequence.
`default_nettype none
module utf8_stream_decoder (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  input  wire logic [7:0]                     in_tdata,   // [7:0] data_byte
  input  wire logic                           in_tlast,   // end_of_text
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  output logic [u8d_pkg::OUT_DATA_W-1:0]      out_tdata,  // [20:0] code_point
  output logic                                out_tuser,  // was_replaced
  output logic                                out_tlast   // last_of_run
);
  import u8d_pkg::*;

  logic  fire;
  push_t push;
  res_t  rd_data;
  logic  room2;

  assign in_tready = room2;
  assign fire      = in_tvalid && in_tready;

  u8d_decode u_decode (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (fire),
    .data_byte   (in_tdata),
    .end_of_text (in_tlast),
    .push        (push)
  );

  u8d_outq u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .room2    (room2),
    .rd_valid (out_tvalid),
    .rd_ready (out_tready),
    .rd_data  (rd_data)
  );

  assign out_tdata = OUT_DATA_W'(rd_data.code_point);
  assign out_tuser = rd_data.was_replaced;
  assign out_tlast = rd_data.last_of_run;

endmodule
`default_nettype wire

FILE: dv/cp_stream_checker.sv
// Checker for the UTF-8 stream decoder: predicts code points from input requests and compares.
module cp_stream_checker (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  input  wire logic                           in_tready,
  input  wire logic [7:0]                     in_tdata,   // [7:0] data_byte
  input  wire logic                           in_tlast,   // end_of_text
  input  wire logic                           out_tvalid,
  input  wire logic                           out_tready,
  input  wire logic [u8d_pkg::OUT_DATA_W-1:0] out_tdata,  // [20:0] code_point
  input  wire logic                           out_tuser,  // was_replaced
  input  wire logic                           out_tlast,  // last_of_run
  output int                                  fail_count,
  output int                                  pending,
  output int                                  cp_checked,
  output int                                  fffd_checked
);
  import u8d_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic [REM_W-1:0] cont_left;
  logic [CP_W-1:0]  cp_accum;
  res_t             cp_expect_q[$];
  res_t             step_res[2];
  int               step_n;
  int               mismatches = 0;
  int               seen_total = 0;
  int               seen_fffd  = 0;

  function automatic void add_result(logic [CP_W-1:0] cp, logic repl);
    step_res[step_n] = '{code_point: cp, was_replaced: repl, last_of_run: 1'b0};
    step_n++;
  endfunction

  // byte seen with no sequence open
  function automatic void open_or_emit(logic [7:0] b);
    if (b[7] == 1'b0) begin
      add_result(CP_W'(b), 1'b0);
    end else if (b[7:5] == 3'b110) begin
      cont_left = 2'd1;
      cp_accum  = CP_W'(b[4:0]);
    end else if (b[7:4] == 4'b1110) begin
      cont_left = 2'd2;
      cp_accum  = CP_W'(b[3:0]);
    end else if (b[7:3] == 5'b11110) begin
      cont_left = 2'd3;
      cp_accum  = CP_W'(b[2:0]);
    end else begin
      add_result(REPLACEMENT_CP, 1'b1);
    end
  endfunction

  function automatic void decode_byte(logic [7:0] b, logic eot);
    step_n = 0;
    if (cont_left != '0) begin
      if (b[7:6] == 2'b10) begin
        cp_accum  = {cp_accum[CP_W-7:0], b[5:0]};
        cont_left = cont_left - 2'd1;
        if (cont_left == '0) begin
          add_result(cp_accum, 1'b0);
          cp_accum = '0;
        end
      end else begin
        // interrupted sequence: substitute, then decode this byte afresh
        add_result(REPLACEMENT_CP, 1'b1);
        cont_left = '0;
        cp_accum  = '0;
        open_or_emit(b);
      end
    end else begin
      open_or_emit(b);
    end
    if (eot) begin
      if (cont_left != '0) add_result(REPLACEMENT_CP, 1'b1);
      cont_left = '0;
      cp_accum  = '0;
    end
    if (step_n > 0) step_res[step_n-1].last_of_run = 1'b1;
    for (int i = 0; i < step_n; i++) cp_expect_q.insert(cp_expect_q.size(), step_res[i]);
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    res_t want;
    if (!rst_n) begin
      cont_left = '0;
      cp_accum  = '0;
      cp_expect_q.delete();
    end else begin
      if (in_tvalid && in_tready) decode_byte(in_tdata, in_tlast);
      if (out_tvalid && out_tready) begin
        seen_total++;
        if (out_tuser) seen_fffd++;
        if (cp_expect_q.size() == 0) begin
          report_mismatch("result with no request pending", 32'(out_tdata[CP_W-1:0]), 0);
        end else begin
          want = cp_expect_q.pop_front();
          if (out_tdata[CP_W-1:0] !== want.code_point)
            report_mismatch("code_point", 32'(out_tdata[CP_W-1:0]), 32'(want.code_point));
          if (out_tuser !== want.was_replaced)
            report_mismatch("was_replaced", 32'(out_tuser), 32'(want.was_replaced));
          if (out_tlast !== want.last_of_run)
            report_mismatch("last_of_run", 32'(out_tlast), 32'(want.last_of_run));
        end
      end
    end
    fail_count   <= mismatches;
    pending      <= cp_expect_q.size();
    cp_checked   <= seen_total;
    fffd_checked <= seen_fffd;
  end

endmodule

FILE: dv/tb_top.sv
// Testbench top for the UTF-8 stream decoder: stimulus, receiver stalls and verdict.
module tb_top;
  import u8d_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [7:0]            in_tdata   = 8'h00;
  logic                  in_tlast   = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;
  logic                  out_tlast;

  int fail_count;
  int pending;
  int cp_checked;
  int fffd_checked;

  int bytes_sent  = 0;
  int burst_left  = 0;
  int steady_left = 0;
  int hold_req    = 0;

  always #5 clk = ~clk;

  utf8_stream_decoder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  cp_stream_checker chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tlast     (in_tlast),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tuser    (out_tuser),
    .out_tlast    (out_tlast),
    .fail_count   (fail_count),
    .pending      (pending),
    .cp_checked   (cp_checked),
    .fffd_checked (fffd_checked)
  );

  initial begin
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // offer one byte, wait for acceptance, then maybe close the burst with a gap
  task automatic send_byte(logic [7:0] b, logic l);
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= l;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    bytes_sent++;
    if (steady_left > 0) begin
      steady_left--;
    end else if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = $urandom_range(0, 24);
    end
  endtask

  // receiver: segments of different stall patterns, long hold-offs on request
  initial begin
    int mode;
    int seg;
    int k;
    int held;
    int holds_served;
    holds_served = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      mode = $urandom_range(0, 3);
      seg  = $urandom_range(20, 150);
      for (k = 0; k < seg; k++) begin
        if (holds_served != hold_req) begin
          holds_served++;
          out_tready <= 1'b0;
          for (held = 0; held < 80; held++) @(posedge clk);
        end
        case (mode)
          0: out_tready <= 1'b1;
          1: out_tready <= ($urandom_range(0, 9) < 7);
          2: out_tready <= ($urandom_range(0, 3) == 0);
          default: out_tready <= (k % 3 == 0);
        endcase
        @(posedge clk);
      end
    end
  end

  initial begin
    logic [7:0] dir_bytes[25];
    logic [7:0] seq[$];
    logic       tail_last;
    int         kind;
    int         n;
    int         conts;
    int         holds_made;

    // ASCII extremes, 2/3/4-byte forms (incl. a genuine U+FFFD), lone
    // continuation, invalid lead, interrupted and truncated sequences
    dir_bytes = '{8'h00, 8'h7F, 8'hC2, 8'hA9, 8'hEF, 8'hBF, 8'hBD, 8'hF4, 8'h8F,
                  8'hBF, 8'hBF, 8'h80, 8'hF8, 8'hC3, 8'h41, 8'hE2, 8'h82, 8'hC3,
                  8'hA9, 8'hE2, 8'hFF, 8'hF0, 8'h9F, 8'hF0, 8'hC2};
    holds_made = 0;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < 25; i++) send_byte(dir_bytes[i], (i == 22) || (i == 24));

    while (bytes_sent < 1550) begin
      if ((holds_made == 0 && bytes_sent >= 400) || (holds_made == 1 && bytes_sent >= 1100)) begin
        holds_made++;
        hold_req    <= hold_req + 1;
        steady_left = 40;
      end
      seq.delete();
      kind = $urandom_range(0, 99);
      if (kind < 85) begin
        n = (kind < 70) ? $urandom_range(1, 4) : $urandom_range(2, 4);
        case (n)
          1: seq.insert(seq.size(), {1'b0, 7'($urandom)});
          2: seq.insert(seq.size(), {3'b110, 5'($urandom)});
          3: seq.insert(seq.size(), {4'b1110, 4'($urandom)});
          default: seq.insert(seq.size(), {5'b11110, 3'($urandom)});
        endcase
        // broken sequences stop short of their continuation count
        conts = (kind < 70) ? n - 1 : $urandom_range(0, n - 2);
        for (int i = 0; i < conts; i++) seq.insert(seq.size(), {2'b10, 6'($urandom)});
        tail_last = (kind < 70) ? ($urandom_range(0, 11) == 0) : ($urandom_range(0, 1) == 1);
      end else begin
        seq.insert(seq.size(), 8'($urandom));
        tail_last = ($urandom_range(0, 7) == 0);
      end
      for (int i = 0; i < seq.size(); i++)
        send_byte(seq[i], tail_last && (i == seq.size() - 1));
    end
    in_tvalid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("run covered %0d bytes (directed forms, then random text with broken and noise bytes)",
             bytes_sent);
    $display("%0d code points compared, %0d substitutes, %0d long receiver hold-offs",
             cp_checked, fffd_checked, holds_made);
    if (fail_count == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/u8d_pkg.sv
hw/rtl/u8d_decode.sv
hw/rtl/u8d_outq.sv
hw/rtl/utf8_stream_decoder.sv
dv/cp_stream_checker.sv
dv/tb_top.sv
